// ===== src/particle_pool_update_assert.svh =====
// ----------------------------------------------------------------------------
// particle_pool_update_assert
// assertion macros shared by the particle pool modules
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_UPDATE_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_ASSERT_SVH

`ifndef SYNTHESIS
// implication checked on every clock edge outside reset
`define PPU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("particle pool assertion failed");
// condition that must never hold
`define PPU_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("particle pool assertion failed");
// condition that must hold in the cycle after the trigger
`define PPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("particle pool assertion failed");
`else
`define PPU_ASSERT_IMPL(lbl, ante, cons)
`define PPU_ASSERT_NEVER(lbl, expr)
`define PPU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// types, codes and arithmetic helpers of the particle pool
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_LIFE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_X      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_Y      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_Z      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY_HALF = 3'd4;

  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam int InDataW  = 168;
  localparam int OutDataW = 144;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_TICK_PRE,
    ST_TICK,
    ST_FLUSH
  } state_e;

  // one pool slot as stored in the memory
  typedef struct packed {
    logic signed [31:0] life;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [15:0]        size;
  } slot_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        size;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } res_t;

  typedef struct packed {
    logic can_emit;
    logic can_flush;
  } out_stat_t;

  // clamp a 35-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/ppu_mem.sv =====
// ----------------------------------------------------------------------------
// ppu_mem
// slot memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ppu_mem import ppu_pkg::*; #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  slot_t            wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output slot_t            rd_data_o
);

  slot_t mem_q [Depth];
  slot_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== src/ppu_out.sv =====
// ----------------------------------------------------------------------------
// ppu_out
// holds the newest result of a tick until the next one shows whether it is
// the last, and drives the output register
// ----------------------------------------------------------------------------
`include "particle_pool_update_assert.svh"

module ppu_out import ppu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                emit_i,
  input  res_t                emit_res_i,
  input  logic                flush_i,
  output out_stat_t           stat_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // pos_x, pos_y, pos_z, size, red, green, blue, alpha
  output logic                m_axis_tlast,
  output logic                m_axis_tuser   // none_alive
);

  logic p_valid_q;
  res_t p_res_q;
  logic o_valid_q;
  res_t o_res_q;
  logic o_last_q;
  logic o_none_q;
  logic o_free;

  assign o_free          = !o_valid_q || m_axis_tready;
  assign stat_o.can_emit  = !p_valid_q || o_free;
  assign stat_o.can_flush = o_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (emit_i) begin
        p_valid_q <= 1'b1;
        if (p_valid_q) begin
          o_valid_q <= 1'b1;
        end else if (m_axis_tready) begin
          o_valid_q <= 1'b0;
        end
      end else if (flush_i) begin
        p_valid_q <= 1'b0;
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      p_res_q <= emit_res_i;
      if (p_valid_q) begin
        o_res_q  <= p_res_q;
        o_last_q <= 1'b0;
        o_none_q <= 1'b0;
      end
    end else if (flush_i) begin
      o_last_q <= 1'b1;
      if (p_valid_q) begin
        o_res_q  <= p_res_q;
        o_none_q <= 1'b0;
      end else begin
        o_res_q  <= '0;
        o_none_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_res_q.alpha, o_res_q.blue, o_res_q.green, o_res_q.red,
                          o_res_q.size, o_res_q.pos_z, o_res_q.pos_y, o_res_q.pos_x};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_none_q;

  `PPU_ASSERT_IMPL(a_emit_room, emit_i, stat_o.can_emit)
  `PPU_ASSERT_NEVER(a_emit_flush, emit_i && flush_i)
  `PPU_ASSERT_NEXT(a_flush_last, flush_i, m_axis_tvalid && m_axis_tlast)
  `PPU_ASSERT_IMPL(a_none_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

endmodule

// ===== src/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update
// fixed pool of particles advanced by Euler steps in Q16.16
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel; tuser selects spawn (0) or
// tick (1). A spawn scans the slot memory round-robin for a free slot, one
// slot per cycle, and writes the new particle; the scan goes through the
// single read port of the slot memory. A tick first computes the gravity
// step in a prep state, then streams every slot through a three-stage
// read/update/write-back pipeline, one slot a cycle while the receiver
// keeps up. One word leaves on m_axis for each live particle, tlast on the
// final one; a tick with nothing alive sends a single word with tuser
// (none_alive) set. Input is taken only when the engine is idle; the last
// word of a tick may still wait in the output register. A receiver stall
// freezes the tick pipeline, nothing is lost. Reset marks every slot free
// through per-slot valid bits, loads the register defaults and needs no
// clearing pass. Configuration writes are always ready and are meant for
// idle periods.
// ----------------------------------------------------------------------------
`include "particle_pool_update_assert.svh"

module particle_pool_update import ppu_pkg::*; #(
  parameter int POOL_SIZE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // delta, vel_x, vel_y, vel_z, red, green, blue, alpha, size, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tuser,   // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pos_x, pos_y, pos_z, size, red, green, blue, alpha
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  output logic                m_axis_tuser,   // none_alive
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam logic [CW-1:0] CntAll  = CW'(POOL_SIZE);
  localparam logic [CW-1:0] CntLast = CW'(POOL_SIZE - 1);
  localparam logic [AW-1:0] SlotTop = AW'(POOL_SIZE - 1);

  // configuration
  logic [30:0]        init_life_q;
  logic signed [31:0] start_x_q, start_y_q, start_z_q;
  logic [30:0]        grav_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_life_q <= 31'd327680;
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_z_q   <= -32'sd1310720;
      grav_q      <= 31'd321454;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INITIAL_LIFE: init_life_q <= cfg_data_i[30:0];
        CFG_START_X:      start_x_q   <= cfg_data_i;
        CFG_START_Y:      start_y_q   <= cfg_data_i;
        CFG_START_Z:      start_z_q   <= cfg_data_i;
        CFG_GRAVITY_HALF: grav_q      <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // input word capture
  logic [InDataW-1:0] in_q;
  logic [16:0]        delta;
  assign delta = in_q[16:0];

  state_e state_q, state_d;
  logic   accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // memory
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  slot_t         wr_data, rd_data;

  ppu_mem #(.Depth(POOL_SIZE), .AddrW(AW)) u_mem (
    .clk_i,
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  logic [POOL_SIZE-1:0] valid_q;
  logic [AW-1:0]        search_q;
  logic [AW-1:0]        ptr_q;
  logic [CW-1:0]        issued_q, chk_q;
  logic signed [32:0]   gd_q;

  // pipeline
  logic          en, issue;
  logic          a_v_q, b_v_q, c_v_q;
  logic [AW-1:0] a_slot_q, b_slot_q, c_slot_q;
  slot_t         b_word_q, c_word_q;
  logic          b_live0_q, b_live1_q, c_live0_q, c_live1_q;
  logic signed [33:0] c_dx_q, c_dy_q, c_dz_q;

  out_stat_t out_stat;
  logic      emit, flush;
  res_t      emit_res;

  // stage a: slot data from memory
  logic               a_present, a_free, a_live0, a_live1;
  logic signed [31:0] a_life_new, a_vy_new;
  slot_t              a_word;
  logic               spawn_done;
  logic [AW-1:0]      spawn_slot;

  assign a_present  = valid_q[a_slot_q];
  assign a_free     = !a_present || rd_data.life[31];
  assign a_live0    = a_present && !rd_data.life[31] && (rd_data.life != '0);
  assign a_life_new = rd_data.life - $signed({15'd0, delta});
  assign a_live1    = !a_life_new[31] && (a_life_new != '0);
  assign a_vy_new   = sat32(35'(rd_data.vel_y) - 35'(gd_q));

  always_comb begin
    a_word      = rd_data;
    a_word.life = a_life_new;
    if (a_live1) begin
      a_word.vel_y = a_vy_new;
    end
  end

  assign spawn_done = (state_q == ST_SPAWN) && a_v_q && (a_free || chk_q == CntLast);
  assign spawn_slot = a_free ? a_slot_q : '0;

  assign en    = (state_q != ST_TICK) || !(c_v_q && c_live1_q) || out_stat.can_emit;
  assign issue = en && issued_q < CntAll
               && ((state_q == ST_SPAWN && !spawn_done) || state_q == ST_TICK);
  assign rd_en   = issue;
  assign rd_addr = ptr_q;

  // stage b: the three motion products
  logic signed [49:0] b_px, b_py, b_pz;
  logic signed [17:0] d_s;
  assign d_s  = $signed({1'b0, delta});
  assign b_px = b_word_q.vel_x * d_s;
  assign b_py = b_word_q.vel_y * d_s;
  assign b_pz = b_word_q.vel_z * d_s;

  // stage c: position sums and write back
  slot_t c_new;
  always_comb begin
    c_new = c_word_q;
    if (c_live1_q) begin
      c_new.pos_x = sat32(35'(c_word_q.pos_x) + 35'(c_dx_q));
      c_new.pos_y = sat32(35'(c_word_q.pos_y) + 35'(c_dy_q));
      c_new.pos_z = sat32(35'(c_word_q.pos_z) + 35'(c_dz_q));
    end
  end

  assign emit  = (state_q == ST_TICK) && en && c_v_q && c_live1_q;
  assign flush = (state_q == ST_FLUSH) && out_stat.can_flush;
  assign emit_res = '{pos_x: c_new.pos_x, pos_y: c_new.pos_y, pos_z: c_new.pos_z,
                      size: c_new.size, red: c_new.red, green: c_new.green,
                      blue: c_new.blue, alpha: c_new.alpha};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = c_slot_q;
    wr_data = c_new;
    if (spawn_done) begin
      wr_en           = 1'b1;
      wr_addr         = spawn_slot;
      wr_data.life    = $signed({1'b0, init_life_q});
      wr_data.pos_x   = start_x_q;
      wr_data.pos_y   = start_y_q;
      wr_data.pos_z   = start_z_q;
      wr_data.vel_x   = in_q[48:17];
      wr_data.vel_y   = in_q[80:49];
      wr_data.vel_z   = in_q[112:81];
      wr_data.red     = in_q[120:113];
      wr_data.green   = in_q[128:121];
      wr_data.blue    = in_q[136:129];
      wr_data.alpha   = in_q[144:137];
      wr_data.size    = in_q[160:145];
    end else if (state_q == ST_TICK && en && c_v_q && c_live0_q) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser == KIND_TICK) ? ST_TICK_PRE : ST_SPAWN;
        end
      end
      ST_SPAWN:    if (spawn_done) state_d = ST_IDLE;
      ST_TICK_PRE: state_d = ST_TICK;
      ST_TICK: begin
        if (issued_q == CntAll && !a_v_q && !b_v_q && !c_v_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH:    if (out_stat.can_flush) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      search_q <= '0;
      ptr_q    <= '0;
      issued_q <= '0;
      chk_q    <= '0;
      a_v_q    <= 1'b0;
      b_v_q    <= 1'b0;
      c_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        ptr_q    <= (s_axis_tuser == KIND_TICK) ? '0 : search_q;
        issued_q <= '0;
        chk_q    <= '0;
      end else if (issue) begin
        ptr_q    <= (ptr_q == SlotTop) ? '0 : ptr_q + 1'b1;
        issued_q <= issued_q + 1'b1;
      end
      if (state_q == ST_SPAWN && a_v_q) begin
        chk_q <= chk_q + 1'b1;
      end
      if (spawn_done) begin
        valid_q[spawn_slot] <= 1'b1;
        if (a_free) begin
          search_q <= a_slot_q;
        end
      end
      if (en) begin
        a_v_q <= issue;
        b_v_q <= a_v_q && (state_q == ST_TICK);
        c_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= s_axis_tdata;
    end
    if (state_q == ST_TICK_PRE) begin
      gd_q <= $signed({1'b0, 32'((48'(grav_q) * 48'(delta)) >> 16)});
    end
    if (en) begin
      a_slot_q  <= ptr_q;
      b_slot_q  <= a_slot_q;
      c_slot_q  <= b_slot_q;
      b_word_q  <= a_word;
      b_live0_q <= a_live0;
      b_live1_q <= a_live0 && a_live1;
      c_word_q  <= b_word_q;
      c_live0_q <= b_live0_q;
      c_live1_q <= b_live1_q;
      c_dx_q    <= b_px[49:16];
      c_dy_q    <= b_py[49:16];
      c_dz_q    <= b_pz[49:16];
    end
  end

  ppu_out u_out (
    .clk_i,
    .rst_ni,
    .emit_i     (emit),
    .emit_res_i (emit_res),
    .flush_i    (flush),
    .stat_o     (out_stat),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  `PPU_ASSERT_NEVER(a_spawn_no_result, state_q == ST_SPAWN && emit)
  `PPU_ASSERT_IMPL(a_pipe_empty_idle, state_q == ST_IDLE, !b_v_q && !c_v_q)
  `PPU_ASSERT_NEXT(a_spawn_marks, spawn_done, valid_q[$past(spawn_slot)])

endmodule

// ===== tb/tb_particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// tb_particle_pool_update
// self-checking bench of the particle pool: spawns and ticks on the input
// stream, every output word compared against a cycle-free pool predictor
// ----------------------------------------------------------------------------
module tb_particle_pool_update;
  import ppu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 64;
  localparam int CycleLimit = 600000;
  localparam logic [16:0] DeltaOne = 17'd65536;

  typedef struct packed {
    logic               kind;
    logic [16:0]        delta;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [15:0]        size;
    logic               empty_tick;  // expect the single none_alive word
  } stim_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] size;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        none;
    logic        last;
  } word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [31:0]         cfg_data_i;

  particle_pool_update dut (.*);

  // predictor state
  logic signed [31:0] life_q [Slots];
  logic signed [31:0] px_q [Slots], py_q [Slots], pz_q [Slots];
  logic signed [31:0] vx_q [Slots], vy_q [Slots], vz_q [Slots];
  logic [47:0]        look_q [Slots];
  int                 scan_from;
  logic [30:0]        life_init;
  logic signed [31:0] org_x, org_y, org_z;
  logic [30:0]        grav_half;

  word_t pending_words [$];
  int    errors;
  int    cycles;
  int    burst_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // product of two Q16.16 values, floored
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  task automatic advance_pool(input stim_t it);
    longint d;
    int     cnt;
    word_t  w;
    if (it.kind == KIND_SPAWN) begin
      int slot;
      slot = -1;
      for (int i = scan_from; i < Slots; i++)
        if (slot < 0 && life_q[i] < 0) slot = i;
      for (int i = 0; i < scan_from; i++)
        if (slot < 0 && life_q[i] < 0) slot = i;
      if (slot < 0) slot = 0;
      else scan_from = slot;
      life_q[slot] = {1'b0, life_init};
      px_q[slot] = org_x;
      py_q[slot] = org_y;
      pz_q[slot] = org_z;
      vx_q[slot] = it.vx;
      vy_q[slot] = it.vy;
      vz_q[slot] = it.vz;
      look_q[slot] = {it.red, it.green, it.blue, it.alpha, it.size};
      return;
    end
    d = it.delta;
    cnt = 0;
    for (int i = 0; i < Slots; i++) begin
      if (life_q[i] <= 0) continue;
      life_q[i] = clamp32(longint'(life_q[i]) - d);
      if (life_q[i] <= 0) continue;  // just died, not shown
      vy_q[i] = clamp32(longint'(vy_q[i]) - qmul(longint'(grav_half), d));
      px_q[i] = clamp32(longint'(px_q[i]) + qmul(vx_q[i], d));
      py_q[i] = clamp32(longint'(py_q[i]) + qmul(vy_q[i], d));
      pz_q[i] = clamp32(longint'(pz_q[i]) + qmul(vz_q[i], d));
      w = '0;
      w.px = px_q[i];
      w.py = py_q[i];
      w.pz = pz_q[i];
      w.size = look_q[i][15:0];
      w.red = look_q[i][47:40];
      w.green = look_q[i][39:32];
      w.blue = look_q[i][31:24];
      w.alpha = look_q[i][23:16];
      pending_words.push_back(w);
      cnt++;
    end
    if (cnt == 0) begin
      w = '0;
      w.none = 1'b1;
      w.last = 1'b1;
      pending_words.push_back(w);
    end else begin
      pending_words[pending_words.size()-1].last = 1'b1;
    end
  endtask

  task automatic send_item(input stim_t it);
    word_t w;
    int    gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {7'd0, it.size, it.alpha, it.blue, it.green, it.red,
                     it.vz, it.vy, it.vx, it.delta};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.empty_tick) begin
      w = '0;
      w.none = 1'b1;
      w.last = 1'b1;
      pending_words.push_back(w);
    end else begin
      advance_pool(it);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_INITIAL_LIFE: life_init = val[30:0];
      CFG_START_X:      org_x = val;
      CFG_START_Y:      org_y = val;
      CFG_START_Z:      org_z = val;
      CFG_GRAVITY_HALF: grav_half = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    // a spawn leaves no word behind but may still be scanning
    repeat (Slots + 20) @(posedge clk_i);
  endtask

  function automatic stim_t random_item(int spawn_pct);
    stim_t it;
    it.kind = ($urandom_range(0, 99) < spawn_pct) ? KIND_SPAWN : KIND_TICK;
    case ($urandom_range(0, 7))
      0:       it.delta = '0;
      1:       it.delta = 17'h1FFFF;
      2:       it.delta = 17'($urandom());
      default: it.delta = 17'($urandom_range(0, 65536));
    endcase
    it.vx = ($urandom_range(0, 9) == 0) ? 32'sh7FFFFFFF : $urandom();
    it.vy = ($urandom_range(0, 9) == 0) ? 32'sh80000000 : $urandom();
    it.vz = $urandom();
    {it.red, it.green, it.blue, it.alpha} = $urandom();
    it.size = 16'($urandom());
    it.empty_tick = 1'b0;
    return it;
  endfunction

  task automatic run_phase(input logic [31:0] li, sx, sy, sz, gh, input int n, pct);
    write_reg(CFG_INITIAL_LIFE, li);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
    write_reg(CFG_GRAVITY_HALF, gh);
    cfg_valid_i <= 1'b0;
    repeat (n) send_item(random_item(pct));
    drain();
  endtask

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp, act);
      errors++;
    end
  endfunction

  // receiver stalls: three modes in turn, always ready, random and mostly stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      case ((cycles / 300) % 3)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        w = pending_words.pop_front();
        check_field("pos_x", w.px, m_axis_tdata[31:0]);
        check_field("pos_y", w.py, m_axis_tdata[63:32]);
        check_field("pos_z", w.pz, m_axis_tdata[95:64]);
        check_field("size", w.size, m_axis_tdata[111:96]);
        check_field("red", w.red, m_axis_tdata[119:112]);
        check_field("green", w.green, m_axis_tdata[127:120]);
        check_field("blue", w.blue, m_axis_tdata[135:128]);
        check_field("alpha", w.alpha, m_axis_tdata[143:136]);
        check_field("none_alive", w.none, m_axis_tuser);
        check_field("last", w.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stim_t rows [$];
    cycles = 0;
    errors = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    for (int i = 0; i < Slots; i++) begin
      life_q[i] = -32'sd65536;
      look_q[i] = '0;
    end
    scan_from = 0;
    life_init = 31'd327680;
    org_x = '0;
    org_y = '0;
    org_z = -32'sd1310720;
    grav_half = 31'd321454;

    // kind, delta, vx, vy, vz, r, g, b, a, size, empty_tick
    rows.push_back('{KIND_TICK, DeltaOne, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b1});
    rows.push_back('{KIND_SPAWN, 17'h1FFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0});
    rows.push_back('{KIND_SPAWN, 17'h0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0});
    rows.push_back('{KIND_SPAWN, 17'h0, 32'sd0, 32'sd65536, -32'sd65536,
                     8'h12, 8'h34, 8'h56, 8'h78, 16'h8000, 1'b0});
    rows.push_back('{KIND_TICK, 17'h0, 32'sh55555555, 32'shAAAAAAAA, 32'sd1,
                     8'hA5, 8'h5A, 8'hC3, 8'h3C, 16'h1234, 1'b0});
    rows.push_back('{KIND_TICK, DeltaOne, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b0});
    rows.push_back('{KIND_TICK, 17'h1FFFF, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b0});
    rows.push_back('{KIND_SPAWN, 17'h0, 32'sd7, -32'sd7, 32'sd100, 8'h01, 8'h80, 8'h7F,
                     8'hFE, 16'h0001, 1'b0});
    rows.push_back('{KIND_TICK, DeltaOne, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b0});
    rows.push_back('{KIND_TICK, DeltaOne, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b0});
    rows.push_back('{KIND_TICK, 17'h1FFFF, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b0});
    rows.push_back('{KIND_TICK, 17'h1FFFF, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b0});
    rows.push_back('{KIND_TICK, 17'h1, 32'sd0, 32'sd0, 32'sd0, 8'h0, 8'h0, 8'h0, 8'h0,
                     16'h0, 1'b0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i]);
    drain();

    // zero life: slots taken but never alive, no gravity
    run_phase(32'd0, 32'd1234, -32'd5, 32'd7, 32'd0, 12, 50);
    run_phase(32'd196608, $urandom(), $urandom(), $urandom(), $urandom_range(0, 655360),
              30, 55);
    run_phase(32'd327680, 32'd0, 32'd0, 32'hFFEC0000, 32'd321454, 25, 45);
    // endless life at the extremes fills the pool and saturates
    run_phase(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 80, 85);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
